### design/keypoint_grid_radius_search_unit_defines.svh
// ----------------------------------------------------------------------------
// keypoint grid radius search: assertion macros
// shared concurrent assertion forms, clocked on clock, disabled in reset
// ----------------------------------------------------------------------------
`ifndef KEYPOINT_GRID_RADIUS_SEARCH_UNIT_DEFINES_SVH
`define KEYPOINT_GRID_RADIUS_SEARCH_UNIT_DEFINES_SVH

// property that must hold at every edge
`define KGRS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// cause in one cycle implies effect in the next
`define KGRS_ASSERT_NEXT(label, cause, effect, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cause) |=> (effect)) \
      else $error(msg);

`endif

### design/kgrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kgrs_pkg
// sizes, codes, payload and control types of the keypoint grid search unit
// ----------------------------------------------------------------------------
package kgrs_pkg;

   // grid and store sizes
   localparam int GRID_COLS  = 64;
   localparam int GRID_ROWS  = 48;
   localparam int KEYPOINTS  = 2048;
   localparam int CELL_SLOTS = 16;
   localparam int CAMERAS    = 2;
   localparam int MAX_HITS   = 63;

   localparam int NUM_CELLS   = CAMERAS * GRID_COLS * GRID_ROWS;
   localparam int CELL_AW     = $clog2(NUM_CELLS);
   localparam int SLOT_DEPTH  = NUM_CELLS * CELL_SLOTS;
   localparam int SLOT_AW     = $clog2(SLOT_DEPTH);
   localparam int STORE_DEPTH = CAMERAS * KEYPOINTS;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int IDX_W       = $clog2(KEYPOINTS);
   localparam int CNT_W       = $clog2(KEYPOINTS + 1);
   localparam int FILL_W      = $clog2(CELL_SLOTS + 1);
   localparam int COL_W       = $clog2(GRID_COLS);
   localparam int ROW_W       = $clog2(GRID_ROWS);
   localparam int HIT_W       = $clog2(MAX_HITS + 1);

   // field widths and fixed point
   localparam int POS_W     = 20;
   localparam int INV_W     = 16;
   localparam int RAD_W     = 16;
   localparam int OCT_W     = 3;
   localparam int LVL_W     = 4;
   localparam int FRAC_BITS = 20;
   localparam int DIF_W     = POS_W + 2;
   localparam int PROD_W    = DIF_W + INV_W + 1;
   localparam int CELLQ_W   = PROD_W + 1 - FRAC_BITS;
   localparam int KP_W      = 2 * POS_W + OCT_W;

   // register file
   localparam int CFG_CAMS = 2;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = POS_W;
   localparam logic [INV_W-1:0] INV_RESET = 16'd6554;

   localparam logic [CSR_AW-1:0] REG_CAM0_MIN_X = 3'd0;
   localparam logic [CSR_AW-1:0] REG_CAM0_MIN_Y = 3'd1;
   localparam logic [CSR_AW-1:0] REG_CAM0_W_INV = 3'd2;
   localparam logic [CSR_AW-1:0] REG_CAM0_H_INV = 3'd3;
   localparam logic [CSR_AW-1:0] REG_CAM1_MIN_X = 3'd4;
   localparam logic [CSR_AW-1:0] REG_CAM1_MIN_Y = 3'd5;
   localparam logic [CSR_AW-1:0] REG_CAM1_W_INV = 3'd6;
   localparam logic [CSR_AW-1:0] REG_CAM1_H_INV = 3'd7;

   // request action codes
   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_INSERT = 2'd1;
   localparam logic [1:0] ACT_QUERY  = 2'd2;

   typedef struct packed {
      logic [1:0]              action;
      logic                    camera;
      logic signed [POS_W-1:0] x_pos;
      logic signed [POS_W-1:0] y_pos;
      logic [OCT_W-1:0]        octave;
      logic [RAD_W-1:0]        radius;
      logic signed [LVL_W-1:0] min_level;
      logic signed [LVL_W-1:0] max_level;
   } req_type;

   typedef struct packed {
      logic [10:0] index;
      logic        hit;
      logic        in_grid;
      logic [5:0]  cell_x;
      logic [5:0]  cell_y;
      logic        overflow;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_DECODE, ST_CLEAR, ST_MUL, ST_RANGE, ST_INS_FILL,
      ST_FILL_RD, ST_FILL_WAIT, ST_SLOT, ST_KP_RD, ST_TEST, ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      EM_NONE, EM_EMPTY, EM_FULL, EM_INS_OUT, EM_INS_FULL, EM_INS_OK,
      EM_HIT, EM_HIT_OVF, EM_FINAL
   } emit_type;

   typedef struct packed {
      logic     load;
      logic     sweep_wr;
      logic     clr_count;
      logic     ins_commit;
      logic     ins_place;
      logic     walk_init;
      logic     fill_latch;
      logic     slot_rd;
      logic     walk_next;
      logic     kp_rd;
      logic     hit_take;
      emit_type emit;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       cam_ok;
      logic       store_full;
      logic       cell_in;
      logic       fill_full;
      logic       range_empty;
      logic       slot_more;
      logic       last_cell;
      logic       match;
      logic       hits_full;
      logic       pend_valid;
      logic       sweep_last;
   } stat_type;

endpackage

### design/kgrs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kgrs_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module kgrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### design/kgrs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kgrs_ctrl
// sequencer for clear sweep, insert and the cell by cell query walk
// ----------------------------------------------------------------------------
`include "keypoint_grid_radius_search_unit_defines.svh"

module kgrs_ctrl import kgrs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.emit = EM_NONE;
      case (state_ff)
         ST_INIT: begin
            cmd.sweep_wr = 1'b1;
            if (stat.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (stat.action)
               ACT_CLEAR: begin
                  cmd.clr_count = 1'b1;
                  state_in      = ST_CLEAR;
               end
               ACT_INSERT: begin
                  if (!stat.cam_ok) begin
                     cmd.emit = EM_EMPTY;
                     state_in = ST_IDLE;
                  end else if (stat.store_full) begin
                     cmd.emit = EM_FULL;
                     state_in = ST_IDLE;
                  end else begin
                     state_in = ST_MUL;
                  end
               end
               ACT_QUERY: begin
                  if (!stat.cam_ok) begin
                     cmd.emit = EM_EMPTY;
                     state_in = ST_IDLE;
                  end else begin
                     state_in = ST_MUL;
                  end
               end
               default: begin
                  cmd.emit = EM_EMPTY;
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_CLEAR: begin
            cmd.sweep_wr = 1'b1;
            if (stat.sweep_last) begin
               cmd.emit = EM_EMPTY;
               state_in = ST_IDLE;
            end
         end
         ST_MUL: begin
            state_in = ST_RANGE;
         end
         ST_RANGE: begin
            if (stat.action == ACT_INSERT) begin
               cmd.ins_commit = 1'b1;
               if (stat.cell_in) begin
                  state_in = ST_INS_FILL;
               end else begin
                  cmd.emit = EM_INS_OUT;
                  state_in = ST_IDLE;
               end
            end else if (stat.range_empty) begin
               cmd.emit = EM_EMPTY;
               state_in = ST_IDLE;
            end else begin
               cmd.walk_init = 1'b1;
               state_in      = ST_FILL_RD;
            end
         end
         ST_INS_FILL: begin
            if (stat.fill_full) begin
               cmd.emit = EM_INS_FULL;
            end else begin
               cmd.ins_place = 1'b1;
               cmd.emit      = EM_INS_OK;
            end
            state_in = ST_IDLE;
         end
         ST_FILL_RD: begin
            state_in = ST_FILL_WAIT;
         end
         ST_FILL_WAIT: begin
            cmd.fill_latch = 1'b1;
            state_in       = ST_SLOT;
         end
         ST_SLOT: begin
            if (stat.slot_more) begin
               cmd.slot_rd = 1'b1;
               state_in    = ST_KP_RD;
            end else if (stat.last_cell) begin
               state_in = ST_DONE;
            end else begin
               cmd.walk_next = 1'b1;
               state_in      = ST_FILL_RD;
            end
         end
         ST_KP_RD: begin
            cmd.kp_rd = 1'b1;
            state_in  = ST_TEST;
         end
         ST_TEST: begin
            state_in = ST_SLOT;
            if (stat.match) begin
               if (stat.hits_full) begin
                  cmd.emit = EM_HIT_OVF;
                  state_in = ST_IDLE;
               end else begin
                  if (stat.pend_valid) cmd.emit = EM_HIT;
                  cmd.hit_take = 1'b1;
               end
            end
         end
         ST_DONE: begin
            cmd.emit = stat.pend_valid ? EM_FINAL : EM_EMPTY;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

   `KGRS_ASSERT_NEXT(a_start_decodes, start && !busy, state_ff == ST_DECODE, "request lost")
   `KGRS_ASSERT(a_test_follows_read, (state_ff == ST_TEST) |-> ($past(state_ff) == ST_KP_RD), "store data not aligned")

endmodule

### design/kgrs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kgrs_datapath
// registers, cell arithmetic, keypoint and grid memories, result register
// ----------------------------------------------------------------------------
`include "keypoint_grid_radius_search_unit_defines.svh"

module kgrs_datapath import kgrs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  req_type           req_data,
   input  cmd_type           cmd,
   output stat_type          stat,
   input  logic              csr_valid,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_data,
   output logic              rsp_valid,
   output rsp_type           rsp_data
);

   localparam logic signed [CELLQ_W-1:0] COLS_Q     = CELLQ_W'(GRID_COLS);
   localparam logic signed [CELLQ_W-1:0] ROWS_Q     = CELLQ_W'(GRID_ROWS);
   localparam logic signed [CELLQ_W-1:0] COLS_MAX_Q = CELLQ_W'(GRID_COLS - 1);
   localparam logic signed [CELLQ_W-1:0] ROWS_MAX_Q = CELLQ_W'(GRID_ROWS - 1);
   localparam logic signed [PROD_W:0]    CEIL_ADD   = (PROD_W+1)'((1 << FRAC_BITS) - 1);
   localparam logic [FRAC_BITS-1:0]      HALF       = {1'b1, {(FRAC_BITS-1){1'b0}}};

   // config registers
   logic signed [POS_W-1:0] min_x_ff [CFG_CAMS];
   logic signed [POS_W-1:0] min_y_ff [CFG_CAMS];
   logic [INV_W-1:0]        winv_ff  [CFG_CAMS];
   logic [INV_W-1:0]        hinv_ff  [CFG_CAMS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < CFG_CAMS; c++) begin
            min_x_ff[c] <= '0;
            min_y_ff[c] <= '0;
            winv_ff[c]  <= INV_RESET;
            hinv_ff[c]  <= INV_RESET;
         end
      end else if (csr_valid) begin
         case (csr_index)
            REG_CAM0_MIN_X: min_x_ff[0] <= csr_data[POS_W-1:0];
            REG_CAM0_MIN_Y: min_y_ff[0] <= csr_data[POS_W-1:0];
            REG_CAM0_W_INV: winv_ff[0]  <= csr_data[INV_W-1:0];
            REG_CAM0_H_INV: hinv_ff[0]  <= csr_data[INV_W-1:0];
            REG_CAM1_MIN_X: min_x_ff[1] <= csr_data[POS_W-1:0];
            REG_CAM1_MIN_Y: min_y_ff[1] <= csr_data[POS_W-1:0];
            REG_CAM1_W_INV: winv_ff[1]  <= csr_data[INV_W-1:0];
            REG_CAM1_H_INV: hinv_ff[1]  <= csr_data[INV_W-1:0];
            default: ;
         endcase
      end
   end

   // request latch
   req_type req_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
   end

   logic cam;
   assign cam = req_ff.camera;

   // offset from grid origin, widened by the radius for a query
   logic signed [DIF_W-1:0]  x_rel, y_rel, rad_s, x_lo, x_hi, y_lo, y_hi;
   logic signed [INV_W:0]    w_s, h_s;
   logic signed [PROD_W-1:0] pxlo_ff, pxhi_ff, pylo_ff, pyhi_ff;

   always_comb begin
      x_rel = DIF_W'(req_ff.x_pos) - DIF_W'(min_x_ff[cam]);
      y_rel = DIF_W'(req_ff.y_pos) - DIF_W'(min_y_ff[cam]);
      rad_s = (req_ff.action == ACT_QUERY) ? signed'(DIF_W'(req_ff.radius)) : '0;
      x_lo  = x_rel - rad_s;
      x_hi  = x_rel + rad_s;
      y_lo  = y_rel - rad_s;
      y_hi  = y_rel + rad_s;
      w_s   = signed'({1'b0, winv_ff[cam]});
      h_s   = signed'({1'b0, hinv_ff[cam]});
   end

   // scaled products, one register stage
   always_ff @(posedge clock) begin
      pxlo_ff <= PROD_W'(x_lo) * PROD_W'(w_s);
      pxhi_ff <= PROD_W'(x_hi) * PROD_W'(w_s);
      pylo_ff <= PROD_W'(y_lo) * PROD_W'(h_s);
      pyhi_ff <= PROD_W'(y_hi) * PROD_W'(h_s);
   end

   // floor, ceil and round to even of the products
   logic signed [CELLQ_W-1:0] lox_q, hix_q, loy_q, hiy_q, lox_c, hix_c, loy_c, hiy_c;
   logic signed [CELLQ_W-1:0] cx_q, cy_q;
   logic signed [PROD_W:0]    hx_ext, hy_ext;
   logic                      up_x, up_y, empty, ins_in;

   always_comb begin
      lox_q  = CELLQ_W'(pxlo_ff >>> FRAC_BITS);
      loy_q  = CELLQ_W'(pylo_ff >>> FRAC_BITS);
      hx_ext = (PROD_W+1)'(pxhi_ff) + CEIL_ADD;
      hy_ext = (PROD_W+1)'(pyhi_ff) + CEIL_ADD;
      hix_q  = CELLQ_W'(hx_ext >>> FRAC_BITS);
      hiy_q  = CELLQ_W'(hy_ext >>> FRAC_BITS);
      lox_c  = (lox_q < 0) ? '0 : lox_q;
      loy_c  = (loy_q < 0) ? '0 : loy_q;
      hix_c  = (hix_q > COLS_MAX_Q) ? COLS_MAX_Q : hix_q;
      hiy_c  = (hiy_q > ROWS_MAX_Q) ? ROWS_MAX_Q : hiy_q;
      empty  = (lox_c >= COLS_Q) || (hix_c < 0) || (loy_c >= ROWS_Q) || (hiy_c < 0);
      // insert has no radius, so the low product is the position itself
      up_x   = (pxlo_ff[FRAC_BITS-1:0] > HALF) ||
               ((pxlo_ff[FRAC_BITS-1:0] == HALF) && lox_q[0]);
      up_y   = (pylo_ff[FRAC_BITS-1:0] > HALF) ||
               ((pylo_ff[FRAC_BITS-1:0] == HALF) && loy_q[0]);
      cx_q   = lox_q + CELLQ_W'(up_x);
      cy_q   = loy_q + CELLQ_W'(up_y);
      ins_in = (cx_q >= 0) && (cx_q < COLS_Q) && (cy_q >= 0) && (cy_q < ROWS_Q);
   end

   logic [COL_W-1:0] lox_ff, hix_ff, ins_cx_ff;
   logic [ROW_W-1:0] loy_ff, hiy_ff, ins_cy_ff;
   logic             empty_ff, ins_in_ff;

   always_ff @(posedge clock) begin
      lox_ff    <= COL_W'(lox_c);
      hix_ff    <= COL_W'(hix_c);
      loy_ff    <= ROW_W'(loy_c);
      hiy_ff    <= ROW_W'(hiy_c);
      empty_ff  <= empty;
      ins_cx_ff <= COL_W'(cx_q);
      ins_cy_ff <= ROW_W'(cy_q);
      ins_in_ff <= ins_in;
   end

   // cell and slot addressing
   function automatic logic [CELL_AW-1:0] cell_addr(logic c, logic [COL_W-1:0] ix,
                                                   logic [ROW_W-1:0] iy);
      return CELL_AW'((CELL_AW'(c) * CELL_AW'(GRID_COLS) + CELL_AW'(ix)) *
                      CELL_AW'(GRID_ROWS) + CELL_AW'(iy));
   endfunction

   function automatic logic [SLOT_AW-1:0] slot_addr(logic [CELL_AW-1:0] cell_a,
                                                   logic [FILL_W-1:0] j);
      return SLOT_AW'(SLOT_AW'(cell_a) * SLOT_AW'(CELL_SLOTS) + SLOT_AW'(j));
   endfunction

   // walk and hit registers
   logic [COL_W-1:0]  ix_ff;
   logic [ROW_W-1:0]  iy_ff;
   logic [FILL_W-1:0] j_ff, f_ff;
   logic [IDX_W-1:0]  li_ff, pend_idx_ff;
   logic              pend_valid_ff;
   logic [HIT_W-1:0]  n_ff;
   logic [CNT_W-1:0]  idx_ff;
   logic [CNT_W-1:0]  cnt_ff [CAMERAS];
   logic [CELL_AW-1:0] sweep_ff;

   logic [CELL_AW-1:0] ins_cell, walk_cell;
   logic [FILL_W-1:0]  fill_rdata;
   logic [IDX_W-1:0]   slot_rdata;
   logic [KP_W-1:0]    kp_rdata;

   assign ins_cell  = cell_addr(cam, ins_cx_ff, ins_cy_ff);
   assign walk_cell = cell_addr(cam, ix_ff, iy_ff);

   always_ff @(posedge clock) begin
      if (cmd.walk_init) begin
         ix_ff <= lox_ff;
         iy_ff <= loy_ff;
      end else if (cmd.walk_next) begin
         if (iy_ff == hiy_ff) begin
            iy_ff <= loy_ff;
            ix_ff <= ix_ff + COL_W'(1);
         end else begin
            iy_ff <= iy_ff + ROW_W'(1);
         end
      end
      if (cmd.fill_latch) begin
         f_ff <= fill_rdata;
         j_ff <= '0;
      end else if (cmd.slot_rd) begin
         j_ff <= j_ff + FILL_W'(1);
      end
      if (cmd.kp_rd) li_ff <= slot_rdata;
      if (cmd.hit_take) pend_idx_ff <= li_ff;
   end

   // hit count, pending hit, keypoint counts and sweep pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         n_ff          <= '0;
         sweep_ff      <= '0;
         for (int c = 0; c < CAMERAS; c++) cnt_ff[c] <= '0;
      end else begin
         if (cmd.load) begin
            pend_valid_ff <= 1'b0;
            n_ff          <= '0;
         end else if (cmd.hit_take) begin
            pend_valid_ff <= 1'b1;
            n_ff          <= n_ff + HIT_W'(1);
         end
         if (cmd.sweep_wr) begin
            sweep_ff <= stat.sweep_last ? '0 : sweep_ff + CELL_AW'(1);
         end
         if (cmd.clr_count) begin
            for (int c = 0; c < CAMERAS; c++) cnt_ff[c] <= '0;
         end else if (cmd.ins_commit) begin
            cnt_ff[cam] <= idx_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) idx_ff <= cnt_ff[req_data.camera];
   end

   // cell fill counts
   logic               fill_we;
   logic [CELL_AW-1:0] fill_waddr, fill_raddr;
   logic [FILL_W-1:0]  fill_wdata;

   always_comb begin
      fill_we    = cmd.sweep_wr || cmd.ins_place;
      fill_waddr = cmd.sweep_wr ? sweep_ff : ins_cell;
      fill_wdata = cmd.sweep_wr ? '0 : fill_rdata + FILL_W'(1);
      fill_raddr = (req_ff.action == ACT_INSERT) ? ins_cell : walk_cell;
   end

   kgrs_ram #(.WIDTH(FILL_W), .DEPTH(NUM_CELLS)) u_fill (
      .clock (clock),
      .we    (fill_we),
      .waddr (fill_waddr),
      .wdata (fill_wdata),
      .raddr (fill_raddr),
      .rdata (fill_rdata)
   );

   // cell slot lists
   kgrs_ram #(.WIDTH(IDX_W), .DEPTH(SLOT_DEPTH)) u_slots (
      .clock (clock),
      .we    (cmd.ins_place),
      .waddr (slot_addr(ins_cell, fill_rdata)),
      .wdata (idx_ff[IDX_W-1:0]),
      .raddr (slot_addr(walk_cell, j_ff)),
      .rdata (slot_rdata)
   );

   // keypoint store
   logic [STORE_AW-1:0] kp_waddr, kp_raddr;
   assign kp_waddr = STORE_AW'(STORE_AW'(cam) * STORE_AW'(KEYPOINTS) +
                               STORE_AW'(idx_ff[IDX_W-1:0]));
   assign kp_raddr = STORE_AW'(STORE_AW'(cam) * STORE_AW'(KEYPOINTS) + STORE_AW'(slot_rdata));

   kgrs_ram #(.WIDTH(KP_W), .DEPTH(STORE_DEPTH)) u_store (
      .clock (clock),
      .we    (cmd.ins_commit),
      .waddr (kp_waddr),
      .wdata ({req_ff.x_pos, req_ff.y_pos, req_ff.octave}),
      .raddr (kp_raddr),
      .rdata (kp_rdata)
   );

   // level filter and strict box test
   logic signed [POS_W-1:0] kx, ky;
   logic signed [LVL_W-1:0] koct;
   logic signed [POS_W:0]   dxs, dys;
   logic [POS_W:0]          dxa, dya;
   logic                    check, lvl_ok, match;

   always_comb begin
      kx     = kp_rdata[KP_W-1 -: POS_W];
      ky     = kp_rdata[OCT_W +: POS_W];
      koct   = signed'(LVL_W'(kp_rdata[OCT_W-1:0]));
      check  = (req_ff.min_level > 0) || (req_ff.max_level >= 0);
      lvl_ok = !check || ((koct >= req_ff.min_level) &&
               !((req_ff.max_level >= 0) && (koct > req_ff.max_level)));
      dxs    = (POS_W+1)'(kx) - (POS_W+1)'(req_ff.x_pos);
      dys    = (POS_W+1)'(ky) - (POS_W+1)'(req_ff.y_pos);
      dxa    = (dxs < 0) ? unsigned'(-dxs) : unsigned'(dxs);
      dya    = (dys < 0) ? unsigned'(-dys) : unsigned'(dys);
      match  = lvl_ok && (dxa < (POS_W+1)'(req_ff.radius)) &&
               (dya < (POS_W+1)'(req_ff.radius));
   end

   // status to the sequencer
   always_comb begin
      stat.action      = req_ff.action;
      stat.cam_ok      = 32'(req_ff.camera) < CAMERAS;
      stat.store_full  = idx_ff >= CNT_W'(KEYPOINTS);
      stat.cell_in     = ins_in_ff;
      stat.fill_full   = fill_rdata >= FILL_W'(CELL_SLOTS);
      stat.range_empty = empty_ff;
      stat.slot_more   = j_ff < f_ff;
      stat.last_cell   = (ix_ff == hix_ff) && (iy_ff == hiy_ff);
      stat.match       = match;
      stat.hits_full   = n_ff == HIT_W'(MAX_HITS);
      stat.pend_valid  = pend_valid_ff;
      stat.sweep_last  = sweep_ff == CELL_AW'(NUM_CELLS - 1);
   end

   // result register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   always_comb begin
      rsp_in       = '0;
      rsp_valid_in = (cmd.emit != EM_NONE);
      case (cmd.emit)
         EM_EMPTY: rsp_in.last = 1'b1;
         EM_FULL: begin
            rsp_in.overflow = 1'b1;
            rsp_in.last     = 1'b1;
         end
         EM_INS_OUT: begin
            rsp_in.index = 11'(idx_ff);
            rsp_in.hit   = 1'b1;
            rsp_in.last  = 1'b1;
         end
         EM_INS_FULL: begin
            rsp_in.index    = 11'(idx_ff);
            rsp_in.hit      = 1'b1;
            rsp_in.cell_x   = 6'(ins_cx_ff);
            rsp_in.cell_y   = 6'(ins_cy_ff);
            rsp_in.overflow = 1'b1;
            rsp_in.last     = 1'b1;
         end
         EM_INS_OK: begin
            rsp_in.index   = 11'(idx_ff);
            rsp_in.hit     = 1'b1;
            rsp_in.in_grid = 1'b1;
            rsp_in.cell_x  = 6'(ins_cx_ff);
            rsp_in.cell_y  = 6'(ins_cy_ff);
            rsp_in.last    = 1'b1;
         end
         EM_HIT: begin
            rsp_in.index = 11'(pend_idx_ff);
            rsp_in.hit   = 1'b1;
         end
         EM_HIT_OVF: begin
            rsp_in.index    = 11'(pend_idx_ff);
            rsp_in.hit      = 1'b1;
            rsp_in.overflow = 1'b1;
            rsp_in.last     = 1'b1;
         end
         EM_FINAL: begin
            rsp_in.index = 11'(pend_idx_ff);
            rsp_in.hit   = 1'b1;
            rsp_in.last  = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `KGRS_ASSERT(a_hits_bounded, n_ff <= HIT_W'(MAX_HITS), "hit count past limit")
   `KGRS_ASSERT(a_hit_has_pending, (cmd.emit == EM_HIT || cmd.emit == EM_HIT_OVF || cmd.emit == EM_FINAL) |-> pend_valid_ff, "hit sent without pending index")

endmodule

### design/keypoint_grid_radius_search_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypoint_grid_radius_search_unit
// per camera uniform grid of keypoints with insert, clear and radius query
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  request   start, busy, req_data          taken when start and not busy
//  result    rsp_valid, rsp_data            one cycle strobe, never held
//  csr       csr_valid, csr_ready, csr_*    write when valid and ready
//
//  after reset busy stays high during a sweep that empties every cell
//  clear runs the same sweep; insert ends early when the store is full
//  query: walks each cell in range, reading its fill count and then each slot;
//  each slot read is followed by a store read, chained through single read ports
//  one request at a time; results cannot be stalled
// ----------------------------------------------------------------------------
module keypoint_grid_radius_search_unit import kgrs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  req_type           req_data,
   output logic              rsp_valid,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_data
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   // sequencer
   kgrs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // datapath and memories
   kgrs_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
